### design/cbpa_pkg.sv
// ============================================================================
// cbpa_pkg
// Shared types and constants for the chunked bump pool allocator.
// ============================================================================
`default_nettype none
package cbpa_pkg;

    localparam int NUM_CHUNKS = 16;
    localparam int IDX_W      = $clog2(NUM_CHUNKS);
    localparam int OPEN_W     = IDX_W + 1;
    localparam int OFF_W      = 17;
    localparam int FAIL_W     = 8;
    localparam int USED_W     = 21;
    localparam int SIZE_W     = 17;
    localparam int ALIGN_W    = 3;
    localparam int MASK_W     = 4;
    localparam int CFG_W      = 17;
    localparam int CFG_ADDR_W = 2;

    localparam logic [OFF_W-1:0]  MAX_CHUNK_BYTES = 17'h10000;
    localparam logic [FAIL_W-1:0] FAIL_MAX        = 8'hFF;
    localparam logic [ALIGN_W-1:0] BASE_ALIGN_LOG2 = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [1:0] STATUS_NO_CHUNK  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_CHUNK_LEN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SMALL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAIL_THR  = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_RESET = 1'b1;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [FAIL_W-1:0] fail;
    } chunk_t;

    typedef struct packed {
        logic shift;
        logic clr;
    } ring_ctl_t;

endpackage
`default_nettype wire

### design/chunked_bump_pool_allocator_top.sv
// ============================================================================
// chunked_bump_pool_allocator_top
// Region pool allocator with per-chunk bump offsets held in a rotating ring.
// ============================================================================
// Usage:
//   Requests enter on s_tvalid/s_tready; s_tuser is the action (0 allocate,
//   1 reset pool), s_tdata carries request_size and align_log2. Results leave
//   on m_tvalid/m_tready with the status in m_tuser.
//   Chunk state lives in a ring of 16 cells that rotates one slot per cycle
//   while a request is in the scan or fail state, past a single compare/update
//   head. A reset or too-large request goes straight to the done state; an
//   allocation walks the ring once in the scan state (it fits or finds no
//   chunk left), and one that opens a new chunk walks it a second time in
//   the fail state to update the failure counts. One request is in work at
//   a time; the next one is taken the cycle after the result register loads.
//   The output register lets a new request be taken while a result waits;
//   if the receiver stalls, the finished request holds until the register
//   frees. Reset (aresetn low, synchronous) clears all chunks, opens one,
//   and restores a chunk length of 4096, max_small 4095, failed_threshold 4.
//   Configuration writes (cfg_we, cfg_addr, cfg_wdata) are registered.
// ============================================================================
`default_nettype none
module chunked_bump_pool_allocator_top
    import cbpa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,  // request_size[16:0], align_log2[19:17]
    input  wire logic                  s_tuser,  // action
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,  // chunk_index, offset, used_total, chunk_total
    output logic [1:0]                 m_tuser   // status
);

    chunk_t    slot [NUM_CHUNKS];
    chunk_t    head_new;
    ring_ctl_t ctl;

    cbpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .head      (slot[0]),
        .head_new  (head_new),
        .ctl       (ctl)
    );

    // The head entry goes back in at the tail after its update.
    for (genvar i = 0; i < NUM_CHUNKS; i++) begin : g_ring
        cbpa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .din     ((i == NUM_CHUNKS - 1) ? head_new : slot[(i + 1) % NUM_CHUNKS]),
            .dout    (slot[i])
        );
    end

endmodule
`default_nettype wire

### design/cbpa_cell.sv
// ============================================================================
// cbpa_cell
// One chunk slot of the rotating ring: bump offset and failure count.
// ============================================================================
`default_nettype none
module cbpa_cell
    import cbpa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire ring_ctl_t ctl,
    input  wire chunk_t    din,
    output chunk_t         dout
);

    chunk_t slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr) begin
            slot_reg <= '0;
        end else if (ctl.shift) begin
            slot_reg <= din;
        end
    end

    assign dout = slot_reg;

endmodule
`default_nettype wire

### design/cbpa_ctrl.sv
// ============================================================================
// cbpa_ctrl
// Sequencer: walks the ring head over every chunk, one per cycle, and
// modifies the entry that passes by.
// ============================================================================
`default_nettype none
module cbpa_ctrl
    import cbpa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,
    output logic [1:0]                 m_tuser,
    input  wire chunk_t                head,
    output chunk_t                     head_new,
    output ring_ctl_t                  ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  base_reg, base_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [OPEN_W-1:0] open_reg, open_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [USED_W-1:0] sum_reg, sum_next;
    logic [1:0]        rstat_reg, rstat_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic [15:0]       roff_reg, roff_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [CFG_W-1:0]  csize_cfg_reg, small_cfg_reg;
    logic [FAIL_W-1:0] thr_reg;
    logic              mval_reg;
    logic [47:0]       mdata_reg;
    logic [1:0]        muser_reg;

    logic              accept, last_idx, in_scan, fits, fail_upd, load_out;
    logic [OFF_W-1:0]  csize, limit, aligned, ext_mask;
    logic [SIZE_W-1:0] req_size;
    logic [ALIGN_W-1:0] req_align, align_eff;

    assign req_size  = s_tdata[16:0];
    assign req_align = s_tdata[19:17];
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign load_out  = (state_reg == ST_DONE) && (!mval_reg || m_tready);

    assign csize     = (csize_cfg_reg > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : csize_cfg_reg;
    assign limit     = (small_cfg_reg < csize) ? small_cfg_reg : csize;
    assign align_eff = (req_align > BASE_ALIGN_LOG2) ? BASE_ALIGN_LOG2 : req_align;

    assign ext_mask  = {{(OFF_W-MASK_W){1'b0}}, mask_reg};
    assign aligned   = (head.off + ext_mask) & ~ext_mask;
    assign fits      = (aligned <= csize) && ((csize - aligned) >= size_reg);
    assign last_idx  = (cnt_reg == IDX_W'(NUM_CHUNKS - 1));
    assign in_scan   = ({1'b0, cnt_reg} < open_reg) && (cnt_reg >= base_reg);
    assign fail_upd  = (cnt_reg >= base_reg) && ({1'b0, cnt_reg} < (open_reg - 1'b1));

    always_comb begin
        head_new  = head;
        ctl.shift = (state_reg == ST_SCAN) || (state_reg == ST_FAIL);
        ctl.clr   = accept && (s_tuser == ACT_RESET);
        if (state_reg == ST_SCAN && !found_reg && in_scan && fits) begin
            head_new.off = aligned + size_reg;
        end
        if (state_reg == ST_FAIL) begin
            if (fail_upd) begin
                head_new.fail = (head.fail == FAIL_MAX) ? FAIL_MAX : head.fail + 1'b1;
            end
            if ({1'b0, cnt_reg} == open_reg) begin
                head_new.off  = size_reg;
                head_new.fail = '0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        base_next  = base_reg;
        cur_next   = cur_reg;
        open_next  = open_reg;
        used_next  = used_reg;
        sum_next   = sum_reg + {{(USED_W-OFF_W){1'b0}}, head_new.off};
        rstat_next = rstat_reg;
        ridx_next  = ridx_reg;
        roff_next  = roff_reg;
        size_next  = size_reg;
        mask_next  = mask_reg;
        unique case (state_reg)
            ST_IDLE: begin
                sum_next = '0;
                if (accept) begin
                    rstat_next = STATUS_OK;
                    ridx_next  = '0;
                    roff_next  = '0;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    base_next  = cur_reg;
                    size_next  = req_size;
                    mask_next  = MASK_W'((5'd1 << align_eff) - 5'd1);
                    if (s_tuser == ACT_RESET) begin
                        cur_next   = '0;
                        used_next  = '0;
                        state_next = ST_DONE;
                    end else if (req_size > limit) begin
                        rstat_next = STATUS_TOO_LARGE;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (!found_reg && in_scan && fits) begin
                    found_next = 1'b1;
                    ridx_next  = cnt_reg;
                    roff_next  = aligned[15:0];
                end
                if (last_idx) begin
                    if (found_next) begin
                        used_next  = sum_next;
                        state_next = ST_DONE;
                    end else if (open_reg >= OPEN_W'(NUM_CHUNKS)) begin
                        rstat_next = STATUS_NO_CHUNK;
                        state_next = ST_DONE;
                    end else begin
                        sum_next   = '0;
                        state_next = ST_FAIL;
                    end
                end
            end
            ST_FAIL: begin
                cnt_next = cnt_reg + 1'b1;
                // Later chunks override earlier ones, so current lands past the last skip.
                if (fail_upd && head.fail >= thr_reg) begin
                    cur_next = cnt_reg + 1'b1;
                end
                if (last_idx) begin
                    used_next  = sum_next;
                    ridx_next  = open_reg[IDX_W-1:0];
                    roff_next  = '0;
                    open_next  = open_reg + 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            open_reg      <= OPEN_W'(1);
            used_reg      <= '0;
            mval_reg      <= 1'b0;
            csize_cfg_reg <= CFG_W'(4096);
            small_cfg_reg <= CFG_W'(4095);
            thr_reg       <= FAIL_W'(4);
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            open_reg  <= open_next;
            used_reg  <= used_next;
            if (load_out) begin
                mval_reg <= 1'b1;
            end else if (m_tready) begin
                mval_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_CHUNK_LEN: csize_cfg_reg <= cfg_wdata;
                    CFG_MAX_SMALL: small_cfg_reg <= cfg_wdata;
                    CFG_FAIL_THR:  thr_reg       <= cfg_wdata[FAIL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        found_reg <= found_next;
        base_reg  <= base_next;
        sum_reg   <= sum_next;
        rstat_reg <= rstat_next;
        ridx_reg  <= ridx_next;
        roff_reg  <= roff_next;
        size_reg  <= size_next;
        mask_reg  <= mask_next;
        if (load_out) begin
            muser_reg <= rstat_reg;
            mdata_reg <= {2'b00, open_reg, used_reg, roff_reg, ridx_reg};
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule
`default_nettype wire
